>>> src/dtp_pkg.sv
package dtp_pkg;

    // Width of the consumed-character counter (saturating)
    localparam int CountBits = 8;

    // Character codes
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;

    // Parse phase
    typedef enum logic [2:0] {
        PH_DONE  = 3'd0,
        PH_BLANK = 3'd1,
        PH_SIGN  = 3'd2,
        PH_INT   = 3'd3,
        PH_DOT   = 3'd4
    } t_phase;

endpackage

>>> src/decimal_tenths_text_parser.sv
// An accepted character is held in the input register, and its result is then held in the
// result register. Throughput: one character per cycle while the result is not stalled;
// set by the combinational accumulator update (multiply by ten and add) between these registers.
// Reset (i_rst_n low, synchronous): parser returns to done and waits for a start
// character; input and output registers are emptied.
module decimal_tenths_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input characters
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tuser,   // [0] new_string
    // parse results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] value_tenths, [23:16] chars_used
    output logic        m_axis_tuser    // [0] parse_ok
);
    import dtp_pkg::*;

    localparam logic [CountBits-1:0] CountTop = {CountBits{1'b1}};

    // Input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_new;

    // Parser state
    t_phase                 r_phase, n_phase;
    logic [15:0]            r_acc, n_acc;
    logic                   r_neg, n_neg;
    logic [CountBits-1:0]   r_used, n_used;

    // Result register
    logic        r_out_valid;
    logic        r_ok;
    logic [15:0] r_value;
    logic [7:0]  r_count;

    logic                 adv;
    t_phase               eff_phase;
    logic [15:0]          base_acc;
    logic                 base_neg;
    logic [CountBits-1:0] base_used;
    logic [CountBits-1:0] inc_used;
    logic                 is_digit;
    logic [3:0]           digit_val;
    logic [15:0]          acc_x10;
    logic                 emit;
    logic                 emit_ok;
    logic [15:0]          ok_value;
    logic [CountBits+7:0] used_ext;
    logic [7:0]           used_sat;

    // Stage advances when the result register is free or being drained
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    // Decode the registered character
    assign is_digit  = (r_char >= ChZero) && (r_char <= ChNine);
    assign digit_val = is_digit ? 4'(r_char - ChZero) : 4'd0;

    // A start character restarts from the blank-skipping phase with cleared state
    assign eff_phase = r_new ? PH_BLANK : r_phase;
    assign base_acc  = r_new ? 16'd0 : r_acc;
    assign base_neg  = r_new ? 1'b0 : r_neg;
    assign base_used = r_new ? '0 : r_used;
    assign inc_used  = (base_used == CountTop) ? base_used : base_used + 1'b1;
    assign acc_x10   = (base_acc << 3) + (base_acc << 1);

    // Next phase
    always_comb begin
        n_phase = eff_phase;
        unique case (eff_phase)
            PH_BLANK: begin
                if (r_char == ChSpace) begin
                    n_phase = PH_BLANK;
                end else if (r_char < ChSpace) begin
                    n_phase = PH_DONE;
                end else if (r_char == ChMinus || r_char == ChPlus) begin
                    n_phase = PH_SIGN;
                end else if (is_digit) begin
                    n_phase = PH_INT;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_SIGN: begin
                n_phase = is_digit ? PH_INT : PH_DONE;
            end
            PH_INT: begin
                if (is_digit) begin
                    n_phase = PH_INT;
                end else if (r_char == ChDot) begin
                    n_phase = PH_DOT;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // Datapath updates and result request
    always_comb begin
        n_acc   = base_acc;
        n_neg   = base_neg;
        n_used  = base_used;
        emit    = 1'b0;
        emit_ok = 1'b0;
        case (eff_phase)
            PH_BLANK: begin
                if (r_char == ChSpace) begin
                    n_used = inc_used;
                end else if (r_char < ChSpace) begin
                    emit = 1'b1;
                end else if (r_char == ChMinus || r_char == ChPlus) begin
                    n_neg  = (r_char == ChMinus);
                    n_used = inc_used;
                end else if (is_digit) begin
                    n_acc  = {12'd0, digit_val};
                    n_used = inc_used;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_SIGN: begin
                if (is_digit) begin
                    n_acc  = {12'd0, digit_val};
                    n_used = inc_used;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    n_acc  = acc_x10 + {12'd0, digit_val};
                    n_used = inc_used;
                end else if (r_char == ChDot) begin
                    n_acc  = acc_x10;
                    n_used = inc_used;
                end else begin
                    n_acc   = acc_x10;
                    emit    = 1'b1;
                    emit_ok = 1'b1;
                end
            end
            PH_DOT: begin
                emit    = 1'b1;
                emit_ok = 1'b1;
                if (is_digit) begin
                    n_acc  = base_acc + {12'd0, digit_val};
                    n_used = inc_used;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Signed value and saturated count for a successful result
    assign ok_value = n_neg ? 16'(16'd0 - n_acc) : n_acc;
    assign used_ext = {8'd0, n_used};
    assign used_sat = (used_ext > (CountBits + 8)'(255)) ? 8'hFF : used_ext[7:0];

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_char <= s_axis_tdata;
            r_new  <= s_axis_tuser;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_acc   <= 16'd0;
            r_neg   <= 1'b0;
            r_used  <= '0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_used  <= n_used;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && emit) begin
            r_ok    <= emit_ok;
            r_value <= emit_ok ? ok_value : 16'd0;
            r_count <= emit_ok ? used_sat : 8'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_count, r_value};
    assign m_axis_tuser  = r_ok;

endmodule
